### rtl/core/dns_message_byte_parser_top_assert.svh
// Assertion macros for the DNS message byte parser.
`ifndef DNS_MESSAGE_BYTE_PARSER_TOP_ASSERT_SVH
`define DNS_MESSAGE_BYTE_PARSER_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define DMBP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define DMBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition must never be true.
`define DMBP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/core/dmbp_pkg.sv
// Shared types and constants of the DNS message byte parser.
`timescale 1ns / 1ps
`default_nettype none

package dmbp_pkg;

  localparam int KIND_W   = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int NLEN_W   = 9;

  // Sections double as result kinds.
  localparam logic [KIND_W-1:0] SEC_ID      = 5'd0;
  localparam logic [KIND_W-1:0] SEC_ARCOUNT = 5'd5;
  localparam logic [KIND_W-1:0] SEC_QNAME   = 5'd6;
  localparam logic [KIND_W-1:0] SEC_QTYPE   = 5'd8;
  localparam logic [KIND_W-1:0] SEC_QCLASS  = 5'd9;
  localparam logic [KIND_W-1:0] SEC_ANAME   = 5'd10;
  localparam logic [KIND_W-1:0] SEC_ATYPE   = 5'd12;
  localparam logic [KIND_W-1:0] SEC_TTL     = 5'd14;
  localparam logic [KIND_W-1:0] SEC_DATA    = 5'd16;
  localparam logic [KIND_W-1:0] SEC_DONE    = 5'd17;
  localparam logic [KIND_W-1:0] KIND_END    = 5'd17;

  localparam logic [STATUS_W-1:0] ST_COMPLETE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;

  localparam logic [7:0] CHAR_DOT = 8'h2E;

  // Result queue sizing.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int LVL_W      = 3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Up to two results caused by one input byte; v1 implies v0.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } emit_t;

endpackage

`default_nettype wire

### rtl/core/dns_message_byte_parser_top.sv
// Top level of the DNS message byte parser: stream ports, parser and result queue.
// A byte's result appears on the master side in the cycle after its transaction, when the queue is empty.
// Throughput: one byte per cycle while the slave side is ready; each byte gives at most one result,
// except a final byte, which can add an end status and so occupy two entries of the four-entry queue.
// The slave side is ready while the queue has room for two results.
// Reset: synchronous, active high; it clears the parse state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module dns_message_byte_parser_top #(
  parameter int NAME_MAX = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] value, [33:32] status, rest zero
  output logic [4:0]  m_tuser    // [4:0] kind
);
  import dmbp_pkg::*;

  logic             in_accept;
  logic             out_accept;
  emit_t            emit;
  result_t          head;
  logic [LVL_W-1:0] level;

  // A byte transaction completes only when two queue entries are free, so the
  // worst case of a final byte with a field result and an end status always fits.
  assign s_tready   = (level <= LVL_W'(FIFO_DEPTH - 2));
  assign in_accept  = s_tvalid && s_tready;
  assign m_tvalid   = (level != '0);
  assign out_accept = m_tvalid && m_tready;

  // The parser decodes the incoming byte against its state combinationally.
  dmbp_parser #(
    .NAME_MAX (NAME_MAX)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .byte_in   (s_tdata),
    .last_byte (s_tlast),
    .emit      (emit)
  );

  // The queue registers the results and decouples the two sides.
  dmbp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .emit  (emit),
    .pop   (out_accept),
    .head  (head),
    .level (level)
  );

  assign m_tdata = {6'b0, head.status, head.value};
  assign m_tuser = head.kind;

`include "dns_message_byte_parser_top_assert.svh"

  `DMBP_ASSERT_NEVER(a_level_bound, level > LVL_W'(FIFO_DEPTH), "result queue overflow")
  `DMBP_ASSERT_SAME(a_v1_on_last, emit.v1, in_accept && s_tlast && emit.v0, "stray second result")
  `DMBP_ASSERT_SAME(a_second_is_end, emit.v1, emit.r1.kind == KIND_END, "bad second kind")
  `DMBP_ASSERT_NEXT(a_level_hold, !in_accept && !out_accept, $stable(level), "idle level change")

endmodule

`default_nettype wire

### rtl/core/dmbp_parser.sv
// Parse state and per-byte decode of the DNS message byte parser.
`timescale 1ns / 1ps
`default_nettype none

module dmbp_parser #(
  parameter int NAME_MAX = 255
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    byte_in,
  input  logic          last_byte,
  output dmbp_pkg::emit_t emit
);
  import dmbp_pkg::*;

  logic [KIND_W-1:0]  section, section_next;
  logic [2:0]         field_byte_count, field_byte_count_next;
  logic [31:0]        field_accumulator, field_accumulator_next;
  logic [7:0]         label_remaining, label_remaining_next;
  logic [NLEN_W-1:0]  decoded_len, decoded_len_next;
  logic               first_label, first_label_next;
  logic               ignore_rest, ignore_rest_next;

  logic [31:0]         acc_shift;
  logic [2:0]          fbc_inc;
  logic [2:0]          fwidth;
  logic                name_full;
  logic                have_r0;
  result_t             r0;
  result_t             end_res;
  logic [STATUS_W-1:0] end_st;

  assign acc_shift = {field_accumulator[23:0], byte_in};
  assign fbc_inc   = field_byte_count + 3'd1;
  assign name_full = (decoded_len >= NLEN_W'(NAME_MAX));

  always_comb begin
    priority if (section == SEC_TTL) begin
      fwidth = 3'd4;
    end else if (section == SEC_DATA) begin
      fwidth = 3'd1;
    end else begin
      fwidth = 3'd2;
    end
  end

  always_comb begin
    section_next           = section;
    field_byte_count_next  = field_byte_count;
    field_accumulator_next = field_accumulator;
    label_remaining_next   = label_remaining;
    decoded_len_next       = decoded_len;
    first_label_next       = first_label;
    ignore_rest_next       = ignore_rest;
    have_r0                = 1'b0;
    r0                     = '0;
    end_st                 = ST_COMPLETE;
    end_res                = '0;

    if (!ignore_rest) begin
      if (section == SEC_QNAME || section == SEC_ANAME) begin
        if (label_remaining == 8'd0) begin
          if (byte_in == 8'd0) begin
            // Root label closes the name and reports its decoded length.
            have_r0      = 1'b1;
            r0.kind      = section + 5'd1;
            r0.value     = VALUE_W'(decoded_len);
            section_next = (section == SEC_QNAME) ? SEC_QTYPE : SEC_ATYPE;
          end else if (!first_label && name_full) begin
            have_r0          = 1'b1;
            r0.kind          = KIND_END;
            r0.value         = VALUE_W'(ST_TOO_LONG);
            r0.status        = ST_TOO_LONG;
            ignore_rest_next = 1'b1;
          end else begin
            if (!first_label) begin
              have_r0          = 1'b1;
              r0.kind          = section;
              r0.value         = VALUE_W'(CHAR_DOT);
              decoded_len_next = decoded_len + NLEN_W'(1);
            end
            first_label_next     = 1'b0;
            label_remaining_next = byte_in;
          end
        end else if (name_full) begin
          have_r0          = 1'b1;
          r0.kind          = KIND_END;
          r0.value         = VALUE_W'(ST_TOO_LONG);
          r0.status        = ST_TOO_LONG;
          ignore_rest_next = 1'b1;
        end else begin
          have_r0              = 1'b1;
          r0.kind              = section;
          r0.value             = VALUE_W'(byte_in);
          decoded_len_next     = decoded_len + NLEN_W'(1);
          label_remaining_next = label_remaining - 8'd1;
        end
      end else if (section < SEC_DONE) begin
        if (fbc_inc >= fwidth) begin
          have_r0                = 1'b1;
          r0.kind                = section;
          r0.value               = acc_shift;
          field_accumulator_next = '0;
          field_byte_count_next  = '0;
          priority if (section == SEC_ARCOUNT || section == SEC_QCLASS) begin
            section_next         = (section == SEC_ARCOUNT) ? SEC_QNAME : SEC_ANAME;
            label_remaining_next = '0;
            decoded_len_next     = '0;
            first_label_next     = 1'b1;
          end else if (section == SEC_DATA) begin
            section_next = SEC_DONE;
          end else begin
            section_next = section + 5'd1;
          end
        end else begin
          field_accumulator_next = acc_shift;
          field_byte_count_next  = fbc_inc;
        end
      end
      end_st         = (section_next == SEC_DONE) ? ST_COMPLETE : ST_TRUNCATED;
      end_res.kind   = KIND_END;
      end_res.value  = VALUE_W'(end_st);
      end_res.status = end_st;
    end

    if (last_byte) begin
      section_next           = SEC_ID;
      field_byte_count_next  = '0;
      field_accumulator_next = '0;
      label_remaining_next   = '0;
      decoded_len_next       = '0;
      first_label_next       = 1'b1;
      ignore_rest_next       = 1'b0;
    end
  end

  // The end status goes behind any result of the same byte. A too-long name
  // gives its own end result, so no second status follows it.
  always_comb begin
    emit = '0;
    if (accept) begin
      if (have_r0) begin
        emit.v0 = 1'b1;
        emit.r0 = r0;
        if (last_byte && !ignore_rest && (r0.kind != KIND_END)) begin
          emit.v1 = 1'b1;
          emit.r1 = end_res;
        end
      end else if (last_byte && !ignore_rest) begin
        emit.v0 = 1'b1;
        emit.r0 = end_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section           <= SEC_ID;
      field_byte_count  <= '0;
      field_accumulator <= '0;
      label_remaining   <= '0;
      decoded_len       <= '0;
      first_label       <= 1'b1;
      ignore_rest       <= 1'b0;
    end else if (accept) begin
      section           <= section_next;
      field_byte_count  <= field_byte_count_next;
      field_accumulator <= field_accumulator_next;
      label_remaining   <= label_remaining_next;
      decoded_len       <= decoded_len_next;
      first_label       <= first_label_next;
      ignore_rest       <= ignore_rest_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dmbp_fifo.sv
// Four-entry result queue with two write slots and one read port.
`timescale 1ns / 1ps
`default_nettype none

module dmbp_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  dmbp_pkg::emit_t        emit,
  input  logic                   pop,
  output dmbp_pkg::result_t      head,
  output logic [dmbp_pkg::LVL_W-1:0] level
);
  import dmbp_pkg::*;

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [1:0]       n_push;
  logic [LVL_W-1:0] level_next;

  assign n_push      = {1'b0, emit.v0} + {1'b0, emit.v1};
  assign wr_ptr_next = wr_ptr + PTR_W'(n_push);
  assign level_next  = level + LVL_W'(n_push) - LVL_W'(pop);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (emit.v0) begin
      mem[wr_ptr] <= emit.r0;
    end
    if (emit.v1) begin
      mem[wr_ptr + PTR_W'(1)] <= emit.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the DNS message byte parser: random messages against a field predictor.
`timescale 1ns / 1ps

module tb_top;
  import dmbp_pkg::*;

  localparam int NAME_LIMIT     = 255;
  localparam int NORMAL_ITEMS   = 220;  // ordinary random bytes, spread over four phases
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 100;

  typedef logic [7:0] octet_t;

  // Tracks the parse of the byte stream and holds the fields it must produce, oldest first.
  class dns_field_scoreboard;
    result_t           expected_fields[$];
    int                errors;
    logic [KIND_W-1:0] section;
    logic [2:0]        field_bytes;
    logic [31:0]       field_acc;
    logic [7:0]        label_left;
    logic [NLEN_W-1:0] name_len;
    bit                first_label;
    bit                ignore_rest;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      section     = SEC_ID;
      field_bytes = '0;
      field_acc   = '0;
      label_left  = '0;
      name_len    = '0;
      first_label = 1'b1;
      ignore_rest = 1'b0;
    endfunction

    function void queue_field(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                              logic [STATUS_W-1:0] st);
      result_t r;
      r.kind   = kind;
      r.value  = value;
      r.status = st;
      expected_fields.push_back(r);
    endfunction

    // The name would grow past its limit: report it and drop the rest of the message.
    function void name_overflow();
      queue_field(KIND_END, 32'(ST_TOO_LONG), ST_TOO_LONG);
      ignore_rest = 1'b1;
    endfunction

    function void note_byte(octet_t b, logic lst);
      logic [STATUS_W-1:0] end_st;
      if (!ignore_rest) begin
        if (section == SEC_QNAME || section == SEC_ANAME) begin
          if (label_left != 0) begin
            if (name_len >= NAME_LIMIT) begin
              name_overflow();
            end else begin
              queue_field(section, 32'(b), ST_COMPLETE);
              name_len++;
              label_left--;
            end
          end else if (b == 8'd0) begin
            // The closing zero reports the decoded name length under the name's end kind.
            queue_field(section + 5'd1, 32'(name_len), ST_COMPLETE);
            section = (section == SEC_QNAME) ? SEC_QTYPE : SEC_ATYPE;
          end else if (!first_label && name_len >= NAME_LIMIT) begin
            name_overflow();
          end else begin
            // Every label after the first is preceded by a dot in the decoded name.
            if (!first_label) begin
              queue_field(section, 32'(CHAR_DOT), ST_COMPLETE);
              name_len++;
            end
            first_label = 1'b0;
            label_left  = b;
          end
        end else if (section < SEC_DONE) begin
          field_acc = {field_acc[23:0], b};
          field_bytes++;
          if (field_bytes >= ((section == SEC_TTL) ? 3'd4 : (section == SEC_DATA) ? 3'd1 : 3'd2))
          begin
            queue_field(section, field_acc, ST_COMPLETE);
            field_acc   = '0;
            field_bytes = '0;
            if (section == SEC_ARCOUNT || section == SEC_QCLASS) begin
              section     = (section == SEC_ARCOUNT) ? SEC_QNAME : SEC_ANAME;
              label_left  = '0;
              name_len    = '0;
              first_label = 1'b1;
            end else begin
              section = section + 5'd1;
            end
          end
        end
        if (lst && !ignore_rest) begin
          end_st = (section == SEC_DONE) ? ST_COMPLETE : ST_TRUNCATED;
          queue_field(KIND_END, 32'(end_st), end_st);
        end
      end
      if (lst) restart();
    endfunction

    task report_mismatch(string what);
      errors++;
      // Keep the log readable if the block goes badly wrong.
      if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
    endtask

    task check_result(logic [4:0] kind, logic [39:0] data);
      result_t want;
      if (expected_fields.size() == 0) begin
        report_mismatch($sformatf("unexpected result: kind %0d value %0h status %0d",
                                  kind, data[31:0], data[33:32]));
        return;
      end
      want = expected_fields.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
      if (data[31:0] !== want.value)
        report_mismatch($sformatf("kind %0d: value %0h, wanted %0h",
                                  want.kind, data[31:0], want.value));
      if (data[33:32] !== want.status)
        report_mismatch($sformatf("kind %0d: status %0d, wanted %0d",
                                  want.kind, data[33:32], want.status));
      if (data[39:34] !== 6'd0)
        report_mismatch($sformatf("kind %0d: padding bits %b not zero", want.kind, data[39:34]));
    endtask
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [4:0]  m_tuser;

  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  dns_field_scoreboard board;

  dns_message_byte_parser_top #(
    .NAME_MAX(NAME_LIMIT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Transactions are sampled at the edge, before any register of the block updates.
  // An output at this edge always belongs to a byte accepted at an earlier edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
      if (s_tvalid && s_tready) board.note_byte(s_tdata, s_tlast);
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(1, 100) > sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction in %0d cycles", WATCHDOG_LIMIT);
      $display("dns_message_byte_parser_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(octet_t b, logic lst);
    if ($urandom_range(1, 100) <= send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(1, 100) <= send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_message(input octet_t msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // Hold the sender off until every pending field has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_fields.size() != 0) @(posedge clk);
  endtask

  function automatic void add_random(ref octet_t msg[$], input int count);
    repeat (count) msg.push_back(octet_t'($urandom_range(0, 255)));
  endfunction

  // Zero to three labels of random content, then the closing zero.
  function automatic void add_name(ref octet_t msg[$], input int max_len);
    int len;
    repeat ($urandom_range(0, 3)) begin
      len = $urandom_range(1, max_len);
      msg.push_back(octet_t'(len));
      add_random(msg, len);
    end
    msg.push_back(8'h00);
  endfunction

  // Four labels of 63 characters decode to exactly the name limit; no closing zero.
  function automatic void add_full_name(ref octet_t msg[$]);
    repeat (4) begin
      msg.push_back(8'd63);
      add_random(msg, 63);
    end
  endfunction

  // Labels keep coming until the decoded name must pass the limit.
  function automatic void add_long_name(ref octet_t msg[$]);
    int decoded;
    int len;
    decoded = -1;
    while (decoded <= NAME_LIMIT) begin
      len = $urandom_range(1, 150);
      msg.push_back(octet_t'(len));
      add_random(msg, len);
      decoded += len + 1;
    end
  endfunction

  // A well-formed message from header to the data byte.
  function automatic void build_message(ref octet_t msg[$], input int max_len);
    add_random(msg, 12);
    add_name(msg, max_len);
    add_random(msg, 4);
    add_name(msg, max_len);
    add_random(msg, 11);
  endfunction

  initial begin
    octet_t msg[$];
    int     pick;
    int     cut;
    int     phase_start;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A message cut off after its first byte gives only a truncated status.
    send_byte(8'h00, 1'b1);

    // A short complete message: header words alternate between all zeros and all ones,
    // an empty question name, a one-character answer name, the largest TTL.
    msg = {8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF,
           8'h00,
           8'hFF, 8'hFF, 8'h00, 8'h00,
           8'h01, 8'hFF, 8'h00,
           8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01,
           8'hFF};
    send_message(msg);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 73;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          sink_stall_pct = 73;
        end
        default: begin
          send_idle_pct  = 15;
          sink_stall_pct = 15;
        end
      endcase
      drain();

      if (phase == 1) begin
        // Question name of exactly the limit, then a short answer name.
        msg.delete();
        add_random(msg, 12);
        add_full_name(msg);
        msg.push_back(8'h00);
        add_random(msg, 4);
        add_name(msg, 8);
        add_random(msg, 11);
        send_message(msg);
      end else if (phase == 3) begin
        // A name that overflows, either on the dot after a full name or at a random
        // point; the bytes after it are ignored.
        msg.delete();
        add_random(msg, 12);
        if ($urandom_range(0, 1) == 1) begin
          add_name(msg, 8);
          add_random(msg, 4);
        end
        if ($urandom_range(0, 1) == 1) begin
          add_full_name(msg);
          msg.push_back(8'h05);
          add_random(msg, 5);
        end else begin
          add_long_name(msg);
        end
        add_random(msg, $urandom_range(0, 3));
        send_message(msg);
      end

      phase_start = items_sent;
      while (items_sent - phase_start < NORMAL_ITEMS / 4) begin
        pick = $urandom_range(0, 99);
        msg.delete();
        if (pick < 15) begin
          // Raw noise of random length.
          add_random(msg, $urandom_range(1, 40));
        end else begin
          build_message(msg, (pick < 25) ? 63 : 8);
          if (pick >= 25 && pick < 45) begin
            // Cut the message short somewhere before its data byte.
            cut = $urandom_range(1, msg.size() - 1);
            while (msg.size() > cut) void'(msg.pop_back());
          end else if (pick >= 45 && pick < 60) begin
            // Trailing bytes after the data byte are ignored.
            add_random(msg, $urandom_range(1, 6));
          end
        end
        send_message(msg);
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (board.expected_fields.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.expected_fields.size()));
    if (board.errors == 0) begin
      $display("dns_message_byte_parser_top: match");
    end else begin
      $display("dns_message_byte_parser_top: mismatch");
    end
    $finish;
  end

endmodule
